// ----- rtl/core/tgrg_pkg.sv -----
// tgrg_pkg: shared types, codes, defaults and the 5x7 font rom for the
// text glyph rectangle generator. No dependencies.
`timescale 1ns / 1ps

package tgrg_pkg;

   localparam int SCREEN_WIDTH_DEF  = 128;
   localparam int SCREEN_HEIGHT_DEF = 128;
   localparam int COL_OFFSET_DEF    = 2;
   localparam int ROW_OFFSET_DEF    = 1;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_FIRST   = 8'h20;
   localparam logic [7:0] CHAR_LAST    = 8'h7E;
   localparam logic [7:0] CHAR_SUBST   = 8'h3F;

   localparam logic [2:0] SPACER_COL = 3'd5;
   localparam logic [2:0] LAST_ROW   = 3'd6;

   typedef enum logic [2:0] {
      CSR_ORIGIN_X  = 3'd0,
      CSR_ORIGIN_Y  = 3'd1,
      CSR_FG_COLOUR = 3'd2,
      CSR_BG_COLOUR = 3'd3,
      CSR_SCALE     = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAW,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic newline;
      logic adv_ok;
      logic last_cand;
      logic hold_valid;
      logic out_free;
   } stat_type;

   typedef struct packed {
      logic [7:0]  x0;
      logic [7:0]  y0;
      logic [7:0]  x1;
      logic [7:0]  y1;
      logic [15:0] colour;
      logic [14:0] count;
   } win_type;

   // column 0 in the top byte, bit 0 of each byte is the top row
   localparam logic [0:4][7:0] GLYPH_ROM [95] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700,
      40'h147F147F14, 40'h242A7F2A12, 40'h2313086462,
      40'h3649552250, 40'h0005030000, 40'h001C224100,
      40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000,
      40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
      40'h4261514946, 40'h2141454B31, 40'h1814127F10,
      40'h2745454539, 40'h3C4A494930, 40'h0171090503,
      40'h3649494936, 40'h064949291E, 40'h0036360000,
      40'h0056360000, 40'h0814224100, 40'h1414141414,
      40'h0041221408, 40'h0201510906, 40'h324979413E,
      40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
      40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
      40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100,
      40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
      40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
      40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
      40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
      40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
      40'h0708700807, 40'h6151494543, 40'h007F414100,
      40'h0204081020, 40'h0041417F00, 40'h0402010204,
      40'h4040404040, 40'h0001020400, 40'h2054545478,
      40'h7F48444438, 40'h3844444420, 40'h384444487F,
      40'h3854545418, 40'h087E090102, 40'h0C5252523E,
      40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
      40'h7F10284400, 40'h00417F4000, 40'h7C04180478,
      40'h7C08040478, 40'h3844444438, 40'h7C14141408,
      40'h081414187C, 40'h7C08040408, 40'h4854545420,
      40'h043F444020, 40'h3C4040207C, 40'h1C2040201C,
      40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
      40'h4464544C44, 40'h0008364100, 40'h00007F0000,
      40'h0041360800, 40'h1008081008
   };

endpackage

// ----- rtl/core/tgrg_ctrl.sv -----
// tgrg_ctrl: sequencing state machine of the glyph rectangle generator.
// Depends on tgrg_pkg; drives commands into tgrg_datapath.
`timescale 1ns / 1ps

module tgrg_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  tgrg_pkg::stat_type stat,
   output tgrg_pkg::cmd_type  cmd
);
   import tgrg_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               // a newline only moves the cursor
               if (!stat.newline) begin
                  state_in = ST_DRAW;
               end
            end
         end
         ST_DRAW: begin
            cmd.step = stat.adv_ok;
            if (stat.adv_ok && stat.last_cand) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!stat.hold_valid) begin
               state_in = ST_IDLE;
            end else if (stat.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/core/tgrg_datapath.sv -----
// tgrg_datapath: registers, cursor, square walker, clipper, hold and output
// words of the glyph rectangle generator. Depends on tgrg_pkg.
`timescale 1ns / 1ps

module tgrg_datapath #(
   parameter int SCREEN_WIDTH  = tgrg_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = tgrg_pkg::SCREEN_HEIGHT_DEF,
   parameter int COL_OFFSET    = tgrg_pkg::COL_OFFSET_DEF,
   parameter int ROW_OFFSET    = tgrg_pkg::ROW_OFFSET_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   input  logic [7:0]         req_char_code,
   input  logic               req_new_text,
   input  tgrg_pkg::cmd_type  cmd,
   output tgrg_pkg::stat_type stat,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output tgrg_pkg::win_type  rsp_win,
   output logic               rsp_last_of_char
);
   import tgrg_pkg::*;

   localparam logic signed [17:0] SW_S = 18'(SCREEN_WIDTH);
   localparam logic signed [17:0] SH_S = 18'(SCREEN_HEIGHT);
   localparam logic signed [17:0] CO_S = 18'(COL_OFFSET);
   localparam logic signed [17:0] RO_S = 18'(ROW_OFFSET);

   // configuration
   logic [15:0] origin_x_ff, origin_y_ff, fg_ff, bg_ff;
   logic [4:0]  scale_ff;

   // cursor and square walker
   logic [15:0]     cursor_x_ff, cursor_y_ff;
   logic [15:0]     px_ff, py_ff, base_y_ff;
   logic [2:0]      col_ff, row_ff;
   logic [0:4][7:0] glyph_ff;

   // hold word waits for the next visible square to decide last_of_char
   logic    hold_valid_ff;
   win_type hold_ff;
   logic    out_valid_ff;
   win_type out_ff;
   logic    out_last_ff;

   logic [15:0] start_x, start_y, scale16, six_s, eight_s;
   logic [7:0]  code_fix, code_off;
   logic        newline;
   logic        tall;
   logic [7:0]  tall_h;
   logic [7:0]  col_bits;
   logic        bit_set;
   logic        vis;
   logic        out_free;
   logic        move_out;
   logic signed [17:0] cx_s, cy_s, cw_s, ch_s;
   logic signed [17:0] xl, yl, wl, hl, wc, hc;
   logic signed [17:0] x0_w, y0_w, x1_w, y1_w;
   logic [17:0] area;
   win_type     cand;

   assign newline  = (req_char_code == CHAR_NEWLINE);
   assign code_fix = (req_char_code < CHAR_FIRST || req_char_code > CHAR_LAST) ?
                     CHAR_SUBST : req_char_code;
   assign code_off = code_fix - CHAR_FIRST;
   assign start_x  = req_new_text ? origin_x_ff : cursor_x_ff;
   assign start_y  = req_new_text ? origin_y_ff : cursor_y_ff;
   assign scale16  = {11'd0, scale_ff};
   assign six_s    = {9'd0, scale_ff, 2'b00} + {10'd0, scale_ff, 1'b0};
   assign eight_s  = {8'd0, scale_ff, 3'b000};
   assign tall_h   = {scale_ff, 3'b000} - {3'd0, scale_ff};
   assign tall     = (col_ff == SPACER_COL) && (scale_ff != 5'd1);

   always_comb begin
      case (col_ff)
         3'd0:    col_bits = glyph_ff[0];
         3'd1:    col_bits = glyph_ff[1];
         3'd2:    col_bits = glyph_ff[2];
         3'd3:    col_bits = glyph_ff[3];
         3'd4:    col_bits = glyph_ff[4];
         default: col_bits = 8'd0;
      endcase
   end
   assign bit_set = col_bits[row_ff];

   // clip the current square to the screen
   always_comb begin
      cx_s = {{2{px_ff[15]}}, px_ff};
      cy_s = {{2{py_ff[15]}}, py_ff};
      cw_s = {13'd0, scale_ff};
      ch_s = tall ? {10'd0, tall_h} : {13'd0, scale_ff};
      xl   = cx_s[17] ? 18'sd0 : cx_s;
      wl   = cx_s[17] ? cw_s + cx_s : cw_s;
      yl   = cy_s[17] ? 18'sd0 : cy_s;
      hl   = cy_s[17] ? ch_s + cy_s : ch_s;
      vis  = (cx_s < SW_S) && (cy_s < SH_S) &&
             !wl[17] && (wl != 18'sd0) && !hl[17] && (hl != 18'sd0);
      wc   = (xl + wl > SW_S) ? SW_S - xl : wl;
      hc   = (yl + hl > SH_S) ? SH_S - yl : hl;
      x0_w = xl + CO_S;
      y0_w = yl + RO_S;
      x1_w = xl + wc - 18'sd1 + CO_S;
      y1_w = yl + hc - 18'sd1 + RO_S;
      area = {9'd0, wc[8:0]} * {9'd0, hc[8:0]};
      cand.x0     = x0_w[7:0];
      cand.y0     = y0_w[7:0];
      cand.x1     = x1_w[7:0];
      cand.y1     = y1_w[7:0];
      cand.colour = (col_ff != SPACER_COL && bit_set) ? fg_ff : bg_ff;
      cand.count  = area[14:0];
   end

   assign out_free = !out_valid_ff || rsp_ready;
   assign move_out = (cmd.step && vis && hold_valid_ff) || cmd.flush;

   assign stat.newline    = newline;
   assign stat.adv_ok     = !vis || !hold_valid_ff || out_free;
   assign stat.last_cand  = (col_ff == SPACER_COL) &&
                            (row_ff == LAST_ROW || scale_ff != 5'd1);
   assign stat.hold_valid = hold_valid_ff;
   assign stat.out_free   = out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= 16'd0;
         origin_y_ff <= 16'd0;
         fg_ff       <= 16'hFFFF;
         bg_ff       <= 16'd0;
         scale_ff    <= 5'd1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ORIGIN_X:  origin_x_ff <= csr_wdata;
            CSR_ORIGIN_Y:  origin_y_ff <= csr_wdata;
            CSR_FG_COLOUR: fg_ff       <= csr_wdata;
            CSR_BG_COLOUR: bg_ff       <= csr_wdata;
            CSR_SCALE:     scale_ff    <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff <= 16'd0;
         cursor_y_ff <= 16'd0;
      end else if (cmd.load) begin
         if (newline) begin
            cursor_x_ff <= origin_x_ff;
            cursor_y_ff <= start_y + eight_s;
         end else begin
            cursor_x_ff <= start_x + six_s;
            cursor_y_ff <= start_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         px_ff     <= start_x;
         py_ff     <= start_y;
         base_y_ff <= start_y;
         col_ff    <= 3'd0;
         row_ff    <= 3'd0;
         glyph_ff  <= GLYPH_ROM[code_off[6:0]];
      end else if (cmd.step) begin
         if (row_ff == LAST_ROW) begin
            row_ff <= 3'd0;
            col_ff <= col_ff + 3'd1;
            px_ff  <= px_ff + scale16;
            py_ff  <= base_y_ff;
         end else begin
            row_ff <= row_ff + 3'd1;
            py_ff  <= py_ff + scale16;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else if (cmd.step && vis) begin
         hold_valid_ff <= 1'b1;
      end else if (cmd.flush) begin
         hold_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step && vis) begin
         hold_ff <= cand;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (move_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move_out) begin
         out_ff      <= hold_ff;
         out_last_ff <= cmd.flush;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_win          = out_ff;
   assign rsp_last_of_char = out_last_ff;

`ifndef SYNTHESIS
   // a held word only moves out when the output word is free
   a_move_needs_room: assert property (@(posedge clock) disable iff (reset)
      move_out |-> out_free)
      else $error("hold word moved into a busy output word");

   // each new byte starts with an empty hold word
   a_load_hold_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !hold_valid_ff)
      else $error("hold word left over from previous byte");

   // the last word of a byte leaves the hold word empty
   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> !hold_valid_ff && out_valid_ff && out_last_ff)
      else $error("flush did not mark the last word");
`endif

endmodule

// ----- rtl/core/text_glyph_rect_generator_core.sv -----
// Top level of the text glyph rectangle generator: controller plus datapath.
// Depends on tgrg_pkg, tgrg_ctrl and tgrg_datapath.
`timescale 1ns / 1ps

// One text byte goes in per req word; each glyph bit becomes a foreground or
// background square of scale by scale pixels, clipped to the screen, and each
// visible square comes out as one rsp word holding the panel window, colour
// and pixel count, with last_of_char on the final word of the byte. A drawn
// byte is accepted, then the datapath walks its squares (42 at scale one, 36
// at any other scale: 35 glyph squares and one spacer strip), then the final
// word, if any, is released. A newline byte only moves the cursor. The square
// walker steps one square per cycle while rsp_ready does not hold off a
// visible square, and the final word is held until the walk ends so that
// last_of_char can be set. The user must write registers through csr_*
// only while the block is idle; the block does not enforce this, and
// csr_ready is always high.
module text_glyph_rect_generator_core #(
   parameter int SCREEN_WIDTH  = tgrg_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = tgrg_pkg::SCREEN_HEIGHT_DEF,
   parameter int COL_OFFSET    = tgrg_pkg::COL_OFFSET_DEF,
   parameter int ROW_OFFSET    = tgrg_pkg::ROW_OFFSET_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_code,
   input  logic        req_new_text,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_win_x0,
   output logic [7:0]  rsp_win_y0,
   output logic [7:0]  rsp_win_x1,
   output logic [7:0]  rsp_win_y1,
   output logic [15:0] rsp_fill_colour,
   output logic [14:0] rsp_pixel_count,
   output logic        rsp_last_of_char
);
   import tgrg_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   win_type  win;

   assign csr_ready = 1'b1;

   tgrg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tgrg_datapath #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .COL_OFFSET    (COL_OFFSET),
      .ROW_OFFSET    (ROW_OFFSET)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_char_code    (req_char_code),
      .req_new_text     (req_new_text),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_win          (win),
      .rsp_last_of_char (rsp_last_of_char)
   );

   assign rsp_win_x0      = win.x0;
   assign rsp_win_y0      = win.y0;
   assign rsp_win_x1      = win.x1;
   assign rsp_win_y1      = win.y1;
   assign rsp_fill_colour = win.colour;
   assign rsp_pixel_count = win.count;

endmodule
